/* hw/rtl/i2p_pkg.sv */
// Shared types, constants and helpers for the infix to postfix converter.
package i2p_pkg;

  // Operator stack geometry.
  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W     = 5;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Input token kinds.
  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_OP  = 3'd1;
  localparam logic [2:0] KIND_LP  = 3'd2;
  localparam logic [2:0] KIND_RP  = 3'd3;
  localparam logic [2:0] KIND_FN  = 3'd4;
  localparam logic [2:0] KIND_END = 3'd5;

  // Result kinds.
  localparam logic [1:0] OKIND_NUM = 2'd0;
  localparam logic [1:0] OKIND_OP  = 2'd1;
  localparam logic [1:0] OKIND_FN  = 2'd2;
  localparam logic [1:0] OKIND_LP  = 2'd3;

  // Stack entry tags.
  localparam logic [1:0] TAG_OP = 2'd0;
  localparam logic [1:0] TAG_FN = 2'd1;
  localparam logic [1:0] TAG_LP = 2'd2;

  // Largest legal codes and the code of the variable x.
  localparam logic [7:0] OP_CODE_MAX = 8'd4;
  localparam logic [7:0] FN_CODE_MAX = 8'd6;
  localparam logic [7:0] FN_CODE_X   = 8'd0;

  // Operator precedence: add and subtract lowest, power highest.
  function automatic logic [1:0] op_prec(input logic [2:0] code);
    logic [1:0] p;
    if (code <= 3'd1) begin
      p = 2'd1;
    end else if (code <= 3'd3) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

endpackage

/* hw/rtl/i2p_stack_ram.sv */
// Operator stack storage: one write port and one registered read port.
module i2p_stack_ram (
  input  logic            clk,
  input  logic            wr_en,
  input  i2p_pkg::ptr_t   wr_addr,
  input  i2p_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  i2p_pkg::ptr_t   rd_addr,
  output i2p_pkg::entry_t rd_data
);
  import i2p_pkg::*;

  entry_t mem [STACK_DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/infix_to_postfix_converter_core.sv */
// Top level of the infix to postfix converter with its operator stack sequencer.
//
// Tokens enter one at a time and leave in postfix order; operators, functions
// and left parentheses wait on a 32-entry stack held in a synchronous RAM.
// A number, the variable x, a left parenthesis or a function is emitted or
// pushed directly, without reading the stack. An operator, right parenthesis
// or end token reads the stack entries it pops one after another, since each
// entry is read through the RAM's single read port before it is popped; an
// operator that reads the stack pushes in a separate step afterwards, while
// one that finds the stack empty pushes at once.
// Each token is pushed and popped at most once. Each result is held back one
// step until it is known whether it is the last one of its token, then goes
// to an output register; the next token is taken while that register still
// waits.
// A stack overflow drops the token and gives a result with overflow set.
// No clearing pass is needed after reset.
module infix_to_postfix_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic       out_last,
  output logic       out_overflow
);
  import i2p_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic [2:0] cur_kind_r, cur_kind_nxt;
  logic [7:0] cur_val_r, cur_val_nxt;

  // Held-back result.
  logic       pend_v_r, pend_v_nxt;
  logic [1:0] pend_kind_r, pend_kind_nxt;
  logic [7:0] pend_val_r, pend_val_nxt;
  logic       pend_ovf_r, pend_ovf_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_val_r, out_val_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  // Stack RAM ports.
  logic   wr_en, rd_en;
  ptr_t   wr_addr, rd_addr;
  entry_t wr_data, rd_data;

  // Sequencer requests.
  logic       emit_req;
  logic [1:0] emit_kind;
  logic [7:0] emit_val;
  logic       emit_ovf;
  logic       push_req;
  logic [1:0] push_tag;
  logic [2:0] push_code;

  logic       out_free, emit_ok, stack_full;
  logic [1:0] top_tag;
  logic [2:0] top_code;
  logic [1:0] pop_kind;
  logic [7:0] pop_val;

  i2p_stack_ram u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_ok    = !pend_v_r || out_free;
  assign stack_full = (count_r >= CNT_W'(STACK_DEPTH));
  assign top_tag    = rd_data[4:3];
  assign top_code   = rd_data[2:0];

  // Result for popping the entry on top of the stack.
  always_comb begin
    if (top_tag == TAG_OP) begin
      pop_kind = OKIND_OP;
      pop_val  = {5'd0, top_code};
    end else if (top_tag == TAG_FN) begin
      pop_kind = OKIND_FN;
      pop_val  = {5'd0, top_code};
    end else begin
      pop_kind = OKIND_LP;
      pop_val  = 8'd0;
    end
  end

  // Token sequencer: reads the top entry, pops, emits and pushes.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_kind_nxt = cur_kind_r;
    cur_val_nxt  = cur_val_r;
    rd_en        = 1'b0;
    rd_addr      = ptr_t'(count_r - 1'b1);
    wr_en        = 1'b0;
    wr_addr      = count_r[PTR_W-1:0];
    wr_data      = '0;
    emit_req     = 1'b0;
    emit_kind    = OKIND_NUM;
    emit_val     = 8'd0;
    emit_ovf     = 1'b0;
    push_req     = 1'b0;
    push_tag     = TAG_OP;
    push_code    = 3'd0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_kind_nxt = in_kind;
          cur_val_nxt  = in_value;
          state_nxt    = S_FIN;
          case (in_kind) inside
            KIND_NUM: begin
              emit_req  = 1'b1;
              emit_kind = OKIND_NUM;
              emit_val  = in_value;
            end
            KIND_FN: begin
              if (in_value == FN_CODE_X) begin
                emit_req  = 1'b1;
                emit_kind = OKIND_FN;
                emit_val  = 8'd0;
              end else if (in_value <= FN_CODE_MAX) begin
                push_req  = 1'b1;
                push_tag  = TAG_FN;
                push_code = in_value[2:0];
              end
            end
            KIND_LP: begin
              push_req = 1'b1;
              push_tag = TAG_LP;
            end
            KIND_OP: begin
              if (in_value <= OP_CODE_MAX) begin
                if (count_r == '0) begin
                  push_req  = 1'b1;
                  push_tag  = TAG_OP;
                  push_code = in_value[2:0];
                end else begin
                  rd_en     = 1'b1;
                  state_nxt = S_EVAL;
                end
              end
            end
            KIND_RP, KIND_END: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_EVAL;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_EVAL: begin
        case (cur_kind_r)
          KIND_OP: begin
            if (top_tag == TAG_LP) begin
              state_nxt = S_PUSH;
            end else if (top_tag == TAG_FN) begin
              // A function on top is popped alone, then the operator goes on.
              emit_req  = 1'b1;
              emit_kind = pop_kind;
              emit_val  = pop_val;
              count_nxt = count_r - 1'b1;
              state_nxt = S_PUSH;
            end else if (op_prec(top_code) >= op_prec(cur_val_r[2:0])) begin
              emit_req  = 1'b1;
              emit_kind = pop_kind;
              emit_val  = pop_val;
              count_nxt = count_r - 1'b1;
              if (count_nxt == '0) begin
                state_nxt = S_PUSH;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ptr_t'(count_nxt - 1'b1);
              end
            end else begin
              state_nxt = S_PUSH;
            end
          end
          KIND_RP: begin
            if (top_tag == TAG_LP) begin
              // The matching left parenthesis is dropped silently.
              count_nxt = count_r - 1'b1;
              state_nxt = S_FIN;
            end else begin
              emit_req  = 1'b1;
              emit_kind = pop_kind;
              emit_val  = pop_val;
              count_nxt = count_r - 1'b1;
              if (count_nxt == '0) begin
                state_nxt = S_FIN;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ptr_t'(count_nxt - 1'b1);
              end
            end
          end
          default: begin
            // End token: flush everything.
            emit_req  = 1'b1;
            emit_kind = pop_kind;
            emit_val  = pop_val;
            count_nxt = count_r - 1'b1;
            if (count_nxt == '0) begin
              state_nxt = S_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ptr_t'(count_nxt - 1'b1);
            end
          end
        endcase
      end

      S_PUSH: begin
        push_req  = 1'b1;
        push_tag  = TAG_OP;
        push_code = cur_val_r[2:0];
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!pend_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Push onto the stack, or report an overflow and drop the token.
    if (push_req) begin
      if (stack_full) begin
        emit_req  = 1'b1;
        emit_kind = OKIND_NUM;
        emit_val  = 8'd0;
        emit_ovf  = 1'b1;
      end else begin
        wr_en     = 1'b1;
        wr_data   = {push_tag, push_code};
        count_nxt = count_r + 1'b1;
      end
    end

    // Hold the whole step while the result path is blocked.
    if (emit_req && !emit_ok) begin
      state_nxt = state_r;
      count_nxt = count_r;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      emit_req  = 1'b0;
    end
  end

  // Held-back result and output register.
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_val_nxt  = pend_val_r;
    pend_ovf_nxt  = pend_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (emit_req) begin
      // A newer result proves the held one is not the token's last.
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_val_nxt   = pend_val_r;
        out_last_nxt  = 1'b0;
        out_ovf_nxt   = pend_ovf_r;
      end
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_val_nxt  = emit_val;
      pend_ovf_nxt  = emit_ovf;
    end else if (state_r == S_FIN && pend_v_r && out_free) begin
      // The token is done, so the held result is its last.
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pend_kind_r;
      out_val_nxt   = pend_val_r;
      out_last_nxt  = 1'b1;
      out_ovf_nxt   = pend_ovf_r;
      pend_v_nxt    = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_kind_r  <= cur_kind_nxt;
    cur_val_r   <= cur_val_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_ovf_r  <= pend_ovf_nxt;
    out_kind_r  <= out_kind_nxt;
    out_val_r   <= out_val_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_val_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule
